[design/scht_pkg.sv]
// Shared types, constants and width helpers for the segment/circle hit test.
`timescale 1ns / 1ps
`default_nettype none
package scht_pkg;

    // Default coordinate width (signed Q16.8).
    localparam int CoordBitsDef = 24;
    // Coordinates wider than this get their differences pre-shifted to RedBits + 1 bits.
    localparam int RedBits      = 24;
    // Entries in the queue between front and back.
    localparam int QueueDepth   = 4;

    // What the back end has to do with an item.
    typedef enum logic [1:0] {
        K_SKIP = 2'd0,
        K_MISS = 2'd1,
        K_TEST = 2'd2
    } t_kind;

    function automatic int pre_shift(input int cb);
        return (cb > RedBits) ? cb - RedBits : 0;
    endfunction

    // kind + start x/y + four differences + radius
    function automatic int qi_bits(input int cb);
        return 2 + 2 * cb + 4 * (cb + 1) + (cb - 1);
    endfunction

endpackage
`default_nettype wire

[design/scht_queue.sv]
// Small show-ahead register FIFO between the front and back ends.
`timescale 1ns / 1ps
`default_nettype none
module scht_queue #(
    parameter int DW    = 8,
    parameter int DEPTH = 4
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_wr,
    input  wire logic [DW-1:0] i_data,
    output logic               o_full,
    input  wire logic          i_rd,
    output logic               o_empty,
    output logic [DW-1:0]      o_data
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [DW-1:0] r_mem [DEPTH];
    logic [PW-1:0] r_wp, r_rp, n_wp, n_rp;
    logic [CW-1:0] r_cnt;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rp];

    assign n_wp = (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
    assign n_rp = (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_wr) begin
                r_wp <= n_wp;
            end
            if (i_rd) begin
                r_rp <= n_rp;
            end
            if (i_wr && !i_rd) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_wr && i_rd) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end
endmodule
`default_nettype wire

[design/scht_front.sv]
// Front end: takes items, forms differences and classifies them.
`timescale 1ns / 1ps
`default_nettype none
module scht_front #(
    parameter int COORD_BITS = scht_pkg::CoordBitsDef
) (
    input  wire logic                                   i_push,
    input  wire logic                                   i_q_full,
    input  wire logic signed [COORD_BITS-1:0]           i_start_x,
    input  wire logic signed [COORD_BITS-1:0]           i_start_y,
    input  wire logic signed [COORD_BITS-1:0]           i_end_x,
    input  wire logic signed [COORD_BITS-1:0]           i_end_y,
    input  wire logic signed [COORD_BITS-1:0]           i_circle_x,
    input  wire logic signed [COORD_BITS-1:0]           i_circle_y,
    input  wire logic [COORD_BITS-2:0]                  i_circle_radius,
    input  wire logic                                   i_own_shot,
    output logic                                        o_wr,
    output logic [scht_pkg::qi_bits(COORD_BITS)-1:0]    o_item
);
    import scht_pkg::*;

    localparam int CB = COORD_BITS;

    typedef struct packed {
        t_kind                kind;
        logic signed [CB-1:0] sx;
        logic signed [CB-1:0] sy;
        logic signed [CB:0]   dxf;
        logic signed [CB:0]   dyf;
        logic signed [CB:0]   fxf;
        logic signed [CB:0]   fyf;
        logic [CB-2:0]        r;
    } t_qitem;

    t_qitem item;

    always_comb begin
        item.sx  = i_start_x;
        item.sy  = i_start_y;
        item.dxf = $signed({i_end_x[CB-1], i_end_x}) - $signed({i_start_x[CB-1], i_start_x});
        item.dyf = $signed({i_end_y[CB-1], i_end_y}) - $signed({i_start_y[CB-1], i_start_y});
        item.fxf = $signed({i_start_x[CB-1], i_start_x})
                 - $signed({i_circle_x[CB-1], i_circle_x});
        item.fyf = $signed({i_start_y[CB-1], i_start_y})
                 - $signed({i_circle_y[CB-1], i_circle_y});
        item.r   = i_circle_radius;
        // vertical segment (incl. a point) never hits
        priority if (i_own_shot) begin
            item.kind = K_SKIP;
        end else if (item.dxf == '0) begin
            item.kind = K_MISS;
        end else begin
            item.kind = K_TEST;
        end
    end

    assign o_wr   = i_push && !i_q_full;
    assign o_item = item;
endmodule
`default_nettype wire

[design/scht_mul.sv]
// Two-stage unsigned multiplier built from four half-width partial products.
`timescale 1ns / 1ps
`default_nettype none
module scht_mul #(
    parameter int AW = 50,
    parameter int BW = 50
) (
    input  wire logic             i_clk,
    input  wire logic             i_en,
    input  wire logic [AW-1:0]    i_a,
    input  wire logic [BW-1:0]    i_b,
    output logic [AW+BW-1:0]      o_p
);
    localparam int AL = AW / 2;
    localparam int AH = AW - AL;
    localparam int BL = BW / 2;
    localparam int BH = BW - BL;
    localparam int PW = AW + BW;

    logic [AL+BL-1:0] r_ll;
    logic [AL+BH-1:0] r_lh;
    logic [AH+BL-1:0] r_hl;
    logic [AH+BH-1:0] r_hh;
    logic [PW-1:0]    r_p, n_p;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ll <= i_a[AL-1:0]  * i_b[BL-1:0];
            r_lh <= i_a[AL-1:0]  * i_b[BW-1:BL];
            r_hl <= i_a[AW-1:AL] * i_b[BL-1:0];
            r_hh <= i_a[AW-1:AL] * i_b[BW-1:BL];
        end
    end

    assign n_p = (PW'(r_hh) << (AL + BL)) + (PW'(r_hl) << AL)
               + (PW'(r_lh) << BL) + PW'(r_ll);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p <= n_p;
        end
    end

    assign o_p = r_p;
endmodule
`default_nettype wire

[design/scht_back.sv]
// Back end: quadratic setup, pipelined square root, nearer root, pipelined divide.
`timescale 1ns / 1ps
`default_nettype none
module scht_back #(
    parameter int COORD_BITS = scht_pkg::CoordBitsDef
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic                                   i_q_empty,
    input  wire logic [scht_pkg::qi_bits(COORD_BITS)-1:0] i_q_item,
    output logic                                        o_q_rd,
    input  wire logic                                   i_pop,
    output logic                                        o_empty,
    output logic                                        o_hit,
    output logic signed [COORD_BITS-1:0]                o_hit_x,
    output logic signed [COORD_BITS-1:0]                o_hit_y,
    output logic                                        o_skipped
);
    import scht_pkg::*;

    localparam int CB  = COORD_BITS;
    localparam int PS  = pre_shift(CB);
    localparam int W   = CB + 1 - PS;     // reduced difference width
    localparam int RW  = CB - 1 - PS;     // reduced radius width
    localparam int DW2 = 2 * W;           // dd, |fd|, |cc|, |c|
    localparam int FDW = 2 * W + 1;       // signed fd, cc
    localparam int DSW = 4 * W;           // discriminant
    localparam int SQW = 2 * W;           // square root bits
    localparam int CW  = 2 * W + 2;       // signed numerator c
    localparam int DXW = CB + 1;          // |full difference|
    localparam int NW  = DXW + DW2;       // dividend
    localparam int QW  = DXW;             // quotient bits

    typedef struct packed {
        t_kind                kind;
        logic signed [CB-1:0] sx;
        logic signed [CB-1:0] sy;
        logic signed [CB:0]   dxf;
        logic signed [CB:0]   dyf;
        logic signed [CB:0]   fxf;
        logic signed [CB:0]   fyf;
        logic [CB-2:0]        r;
    } t_qitem;

    typedef struct packed {
        logic                 v;
        t_kind                kind;
        logic signed [CB-1:0] sx;
        logic signed [CB-1:0] sy;
        logic signed [CB:0]   dxf;
        logic signed [CB:0]   dyf;
    } t_sb;

    typedef struct packed {
        t_sb                   sb;
        logic signed [2*W-1:0] pxx;
        logic signed [2*W-1:0] pyy;
        logic signed [2*W-1:0] pfxd;
        logic signed [2*W-1:0] pfyd;
        logic signed [2*W-1:0] pfx2;
        logic signed [2*W-1:0] pfy2;
        logic [2*RW-1:0]       prr;
    } t_sa;

    typedef struct packed {
        t_sb                  sb;
        logic [DW2-1:0]       dd;
        logic signed [FDW-1:0] fd;
        logic [DW2-1:0]       fdm;
        logic [DW2-1:0]       ccm;
        logic                 ccn;
    } t_sbq;

    typedef struct packed {
        t_sb                   sb;
        logic [DW2-1:0]        dd;
        logic signed [FDW-1:0] fd;
        logic                  ccn;
    } t_sc;

    typedef struct packed {
        t_sb                   sb;
        logic [DW2-1:0]        dd;
        logic signed [FDW-1:0] fd;
        logic [DSW-1:0]        rem;
        logic [SQW-1:0]        root;
    } t_sq;

    typedef struct packed {
        t_sb            sb;
        logic [DW2-1:0] dd;
        logic [DW2-1:0] cm;
        logic [DXW-1:0] dxm;
        logic [DXW-1:0] dym;
        logic           xneg;
        logic           yneg;
    } t_se;

    typedef struct packed {
        t_sb            sb;
        logic [DW2-1:0] dd;
        logic           xneg;
        logic           yneg;
    } t_sf;

    typedef struct packed {
        t_sb            sb;
        logic [DW2-1:0] dd;
        logic           xneg;
        logic           yneg;
        logic [DW2-1:0] xp;
        logic [QW-1:0]  xn;
        logic [QW-1:0]  xq;
        logic [DW2-1:0] yp;
        logic [QW-1:0]  yn;
        logic [QW-1:0]  yq;
    } t_dv;

    logic en;
    t_qitem q_it;

    t_sa  r_a, n_a;
    t_sbq r_b, n_b;
    t_sc  r_c1, r_c2;
    t_sq  r_sq [SQW+1];
    t_sq  n_sq [SQW+1];
    t_se  r_e, n_e;
    t_sf  r_f1, r_f2;
    t_dv  r_dv [QW+1];
    t_dv  n_dv [QW+1];

    logic [DSW-1:0] fd2, ddcc;
    logic [NW-1:0]  px, py;

    logic                 r_out_v;
    logic                 r_out_hit, r_out_skip;
    logic signed [CB-1:0] r_out_x, r_out_y;
    logic signed [CB-1:0] n_x, n_y;

    logic signed [W-1:0]  a_dx, a_dy, a_fx, a_fy;
    logic [RW-1:0]        a_rr;

    logic signed [FDW-1:0] b_fd, b_cc;
    logic [DW2-1:0]        b_dd;

    logic [DSW:0] d_sum;
    logic         d_miss;

    logic signed [CW-1:0] e_s, e_fd, e_c, e_cmag;

    logic [QW-1:0]        h_qx, h_qy;
    logic signed [CB+1:0] h_sx, h_sy;

    // whole pipeline advances together; stalls only when the result is not taken
    assign en     = !r_out_v || i_pop;
    assign q_it   = i_q_item;
    assign o_q_rd = en && !i_q_empty;

    // ---- stage A: reduce and square
    always_comb begin
        a_dx = W'($signed(q_it.dxf) >>> PS);
        a_dy = W'($signed(q_it.dyf) >>> PS);
        a_fx = W'($signed(q_it.fxf) >>> PS);
        a_fy = W'($signed(q_it.fyf) >>> PS);
        a_rr = RW'(q_it.r >> PS);
        n_a.sb.v    = o_q_rd;
        n_a.sb.kind = q_it.kind;
        n_a.sb.sx   = q_it.sx;
        n_a.sb.sy   = q_it.sy;
        n_a.sb.dxf  = q_it.dxf;
        n_a.sb.dyf  = q_it.dyf;
        n_a.pxx  = a_dx * a_dx;
        n_a.pyy  = a_dy * a_dy;
        n_a.pfxd = a_fx * a_dx;
        n_a.pfyd = a_fy * a_dy;
        n_a.pfx2 = a_fx * a_fx;
        n_a.pfy2 = a_fy * a_fy;
        n_a.prr  = a_rr * a_rr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a.sb.v <= 1'b0;
        end else if (en) begin
            r_a <= n_a;
        end
    end

    // ---- stage B: dd, fd, cc
    always_comb begin
        b_dd = DW2'($unsigned(r_a.pxx) + $unsigned(r_a.pyy));
        b_fd = FDW'(r_a.pfxd) + FDW'(r_a.pfyd);
        b_cc = FDW'(r_a.pfx2) + FDW'(r_a.pfy2) - FDW'($signed({1'b0, r_a.prr}));
        n_b.sb  = r_a.sb;
        n_b.dd  = b_dd;
        n_b.fd  = b_fd;
        n_b.fdm = DW2'(b_fd[FDW-1] ? -b_fd : b_fd);
        n_b.ccm = DW2'(b_cc[FDW-1] ? -b_cc : b_cc);
        n_b.ccn = b_cc[FDW-1];
        if (r_a.sb.kind == K_TEST && b_dd == '0) begin
            n_b.sb.kind = K_MISS;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b.sb.v <= 1'b0;
        end else if (en) begin
            r_b <= n_b;
        end
    end

    // ---- stage C: fd*fd and dd*|cc|
    scht_mul #(.AW(DW2), .BW(DW2)) u_mul_fd (
        .i_clk (i_clk),
        .i_en  (en),
        .i_a   (r_b.fdm),
        .i_b   (r_b.fdm),
        .o_p   (fd2)
    );

    scht_mul #(.AW(DW2), .BW(DW2)) u_mul_cc (
        .i_clk (i_clk),
        .i_en  (en),
        .i_a   (r_b.dd),
        .i_b   (r_b.ccm),
        .o_p   (ddcc)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c1.sb.v <= 1'b0;
            r_c2.sb.v <= 1'b0;
        end else if (en) begin
            r_c1 <= '{sb: r_b.sb, dd: r_b.dd, fd: r_b.fd, ccn: r_b.ccn};
            r_c2 <= r_c1;
        end
    end

    // ---- stage D: discriminant, miss on tangent or no crossing
    always_comb begin
        d_sum  = r_c2.ccn ? {1'b0, fd2} + {1'b0, ddcc} : {1'b0, fd2} - {1'b0, ddcc};
        d_miss = r_c2.ccn ? (d_sum == '0) : (ddcc >= fd2);
        n_sq[0].sb   = r_c2.sb;
        n_sq[0].dd   = r_c2.dd;
        n_sq[0].fd   = r_c2.fd;
        n_sq[0].rem  = DSW'(d_sum);
        n_sq[0].root = '0;
        if (r_c2.sb.kind == K_TEST && d_miss) begin
            n_sq[0].sb.kind = K_MISS;
        end
    end

    // ---- square root, one result bit per stage
    for (genvar k = 0; k <= SQW; k++) begin : g_sq
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sq[k].sb.v <= 1'b0;
            end else if (en) begin
                r_sq[k] <= n_sq[k];
            end
        end
    end

    for (genvar k = 0; k < SQW; k++) begin : g_sq_step
        localparam int B = SQW - 1 - k;
        logic [DSW:0] trial;
        always_comb begin
            // (root + 2^B)^2 - root^2
            trial = ((DSW+1)'(r_sq[k].root) << (B + 1)) + ((DSW+1)'(1) << (2 * B));
            n_sq[k+1] = r_sq[k];
            if ({1'b0, r_sq[k].rem} >= trial) begin
                n_sq[k+1].rem  = DSW'({1'b0, r_sq[k].rem} - trial);
                n_sq[k+1].root = r_sq[k].root | (SQW'(1) << B);
            end
        end
    end

    // ---- stage E: root nearer the start, range check
    always_comb begin
        e_s  = $signed({2'b00, r_sq[SQW].root});
        e_fd = CW'(r_sq[SQW].fd);
        priority if (e_fd > 0) begin
            e_c = e_s - e_fd;
        end else if (e_fd < 0) begin
            e_c = -e_fd - e_s;
        end else if (r_sq[SQW].sb.dxf > 0) begin
            e_c = -e_s;
        end else begin
            e_c = e_s;
        end
        e_cmag = e_c[CW-1] ? -e_c : e_c;
        n_e.sb   = r_sq[SQW].sb;
        n_e.dd   = r_sq[SQW].dd;
        n_e.cm   = DW2'(e_cmag);
        n_e.dxm  = DXW'(r_sq[SQW].sb.dxf[CB] ? -r_sq[SQW].sb.dxf : r_sq[SQW].sb.dxf);
        n_e.dym  = DXW'(r_sq[SQW].sb.dyf[CB] ? -r_sq[SQW].sb.dyf : r_sq[SQW].sb.dyf);
        n_e.xneg = r_sq[SQW].sb.dxf[CB] ^ e_c[CW-1];
        n_e.yneg = r_sq[SQW].sb.dyf[CB] ^ e_c[CW-1];
        if (r_sq[SQW].sb.kind == K_TEST && $unsigned(e_cmag) >= CW'(r_sq[SQW].dd)) begin
            n_e.sb.kind = K_MISS;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e.sb.v <= 1'b0;
        end else if (en) begin
            r_e <= n_e;
        end
    end

    // ---- stage F: |d| * |c|
    scht_mul #(.AW(DXW), .BW(DW2)) u_mul_x (
        .i_clk (i_clk),
        .i_en  (en),
        .i_a   (r_e.dxm),
        .i_b   (r_e.cm),
        .o_p   (px)
    );

    scht_mul #(.AW(DXW), .BW(DW2)) u_mul_y (
        .i_clk (i_clk),
        .i_en  (en),
        .i_a   (r_e.dym),
        .i_b   (r_e.cm),
        .o_p   (py)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1.sb.v <= 1'b0;
            r_f2.sb.v <= 1'b0;
        end else if (en) begin
            r_f1 <= '{sb: r_e.sb, dd: r_e.dd, xneg: r_e.xneg, yneg: r_e.yneg};
            r_f2 <= r_f1;
        end
    end

    // ---- stage G: restoring divide by dd, one quotient bit per stage
    always_comb begin
        n_dv[0].sb   = r_f2.sb;
        n_dv[0].dd   = r_f2.dd;
        n_dv[0].xneg = r_f2.xneg;
        n_dv[0].yneg = r_f2.yneg;
        n_dv[0].xp   = px[NW-1:QW];
        n_dv[0].xn   = px[QW-1:0];
        n_dv[0].xq   = '0;
        n_dv[0].yp   = py[NW-1:QW];
        n_dv[0].yn   = py[QW-1:0];
        n_dv[0].yq   = '0;
    end

    for (genvar k = 0; k <= QW; k++) begin : g_dv
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv[k].sb.v <= 1'b0;
            end else if (en) begin
                r_dv[k] <= n_dv[k];
            end
        end
    end

    for (genvar k = 0; k < QW; k++) begin : g_dv_step
        logic [DW2:0] tx, ty;
        logic         gx, gy;
        always_comb begin
            tx = {r_dv[k].xp, r_dv[k].xn[QW-1]};
            ty = {r_dv[k].yp, r_dv[k].yn[QW-1]};
            gx = tx >= {1'b0, r_dv[k].dd};
            gy = ty >= {1'b0, r_dv[k].dd};
            n_dv[k+1]    = r_dv[k];
            n_dv[k+1].xp = DW2'(gx ? tx - {1'b0, r_dv[k].dd} : tx);
            n_dv[k+1].yp = DW2'(gy ? ty - {1'b0, r_dv[k].dd} : ty);
            n_dv[k+1].xn = r_dv[k].xn << 1;
            n_dv[k+1].yn = r_dv[k].yn << 1;
            n_dv[k+1].xq = {r_dv[k].xq[QW-2:0], gx};
            n_dv[k+1].yq = {r_dv[k].yq[QW-2:0], gy};
        end
    end

    // ---- stage H: add offset to start, saturate
    always_comb begin
        h_qx = r_dv[QW].xq;
        h_qy = r_dv[QW].yq;
        h_sx = (CB+2)'(r_dv[QW].sb.sx)
             + (r_dv[QW].xneg ? -$signed({1'b0, h_qx}) : $signed({1'b0, h_qx}));
        h_sy = (CB+2)'(r_dv[QW].sb.sy)
             + (r_dv[QW].yneg ? -$signed({1'b0, h_qy}) : $signed({1'b0, h_qy}));
        if (h_sx[CB+1:CB-1] == 3'b000 || h_sx[CB+1:CB-1] == 3'b111) begin
            n_x = h_sx[CB-1:0];
        end else begin
            n_x = {h_sx[CB+1], {(CB-1){~h_sx[CB+1]}}};
        end
        if (h_sy[CB+1:CB-1] == 3'b000 || h_sy[CB+1:CB-1] == 3'b111) begin
            n_y = h_sy[CB-1:0];
        end else begin
            n_y = {h_sy[CB+1], {(CB-1){~h_sy[CB+1]}}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (en) begin
            r_out_v <= r_dv[QW].sb.v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_hit  <= (r_dv[QW].sb.kind == K_TEST);
            r_out_skip <= (r_dv[QW].sb.kind == K_SKIP);
            r_out_x    <= (r_dv[QW].sb.kind == K_TEST) ? n_x : '0;
            r_out_y    <= (r_dv[QW].sb.kind == K_TEST) ? n_y : '0;
        end
    end

    assign o_empty   = !r_out_v;
    assign o_hit     = r_out_hit;
    assign o_skipped = r_out_skip;
    assign o_hit_x   = r_out_x;
    assign o_hit_y   = r_out_y;
endmodule
`default_nettype wire

[design/segment_circle_hit_test_unit.sv]
// Throughput: one item per cycle unless stalled; sqrt/divide pipelines take one bit per stage.
// The result register holds until popped; while it waits the pipeline stalls and the
// front queue (4 items) keeps taking items.
// Reset (i_rst_n low, synchronous): queue emptied, all pipeline valid bits cleared.
// Top level: front classifier -> item queue -> back-end arithmetic pipeline.
`timescale 1ns / 1ps
`default_nettype none
module segment_circle_hit_test_unit #(
    parameter int COORD_BITS = scht_pkg::CoordBitsDef
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    // input side
    input  wire logic                         push,
    output logic                              full,
    input  wire logic signed [COORD_BITS-1:0] i_start_x,
    input  wire logic signed [COORD_BITS-1:0] i_start_y,
    input  wire logic signed [COORD_BITS-1:0] i_end_x,
    input  wire logic signed [COORD_BITS-1:0] i_end_y,
    input  wire logic signed [COORD_BITS-1:0] i_circle_x,
    input  wire logic signed [COORD_BITS-1:0] i_circle_y,
    input  wire logic [COORD_BITS-2:0]        i_circle_radius,
    input  wire logic                         i_own_shot,
    // result side
    output logic                              empty,
    input  wire logic                         pop,
    output logic                              o_hit,
    output logic signed [COORD_BITS-1:0]      o_hit_x,
    output logic signed [COORD_BITS-1:0]      o_hit_y,
    output logic                              o_skipped
);
    import scht_pkg::*;

    localparam int QIW = qi_bits(COORD_BITS);

    logic           q_full, q_empty, q_wr, q_rd;
    logic [QIW-1:0] q_din, q_dout;

    // Front: forms end-start and start-center, tags own shots and vertical
    // segments so the back end only carries the verdict along.
    scht_front #(.COORD_BITS(COORD_BITS)) u_front (
        .i_push          (push),
        .i_q_full        (q_full),
        .i_start_x       (i_start_x),
        .i_start_y       (i_start_y),
        .i_end_x         (i_end_x),
        .i_end_y         (i_end_y),
        .i_circle_x      (i_circle_x),
        .i_circle_y      (i_circle_y),
        .i_circle_radius (i_circle_radius),
        .i_own_shot      (i_own_shot),
        .o_wr            (q_wr),
        .o_item          (q_din)
    );

    // Queue decouples input acceptance from back-end stalls.
    scht_queue #(.DW(QIW), .DEPTH(QueueDepth)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (q_wr),
        .i_data  (q_din),
        .o_full  (q_full),
        .i_rd    (q_rd),
        .o_empty (q_empty),
        .o_data  (q_dout)
    );

    // Back end: dd/fd/cc, discriminant, bit-serial sqrt stages, nearer root,
    // range check, offset = d*c/dd via bit-serial divide stages, saturation.
    scht_back #(.COORD_BITS(COORD_BITS)) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_q_item  (q_dout),
        .o_q_rd    (q_rd),
        .i_pop     (pop),
        .o_empty   (empty),
        .o_hit     (o_hit),
        .o_hit_x   (o_hit_x),
        .o_hit_y   (o_hit_y),
        .o_skipped (o_skipped)
    );

    assign full = q_full;
endmodule
`default_nettype wire

[dv/testbench.sv]
// Self-checking testbench for the segment/circle hit test unit.
`timescale 1ns / 1ps
`default_nettype none

// Expected hit results in acceptance order; checks each popped result.
class hit_scoreboard;
    typedef struct packed {
        logic        hit;
        logic [23:0] hx;
        logic [23:0] hy;
        logic        skipped;
    } t_hit_res;

    t_hit_res expected_hits[$];
    int       mismatches;

    function automatic longint isqrt(input logic [127:0] v);
        logic [63:0]  root;
        logic [63:0]  cand;
        logic [127:0] sq;
        root = 0;
        for (int b = 55; b >= 0; b--) begin
            cand = root | (64'd1 << b);
            sq = {64'd0, cand} * {64'd0, cand};
            if (sq <= v) root = cand;
        end
        return longint'(root);
    endfunction

    // offset = a*c/den truncated toward zero
    function automatic longint scaled_offset(input longint a, input longint c,
                                             input longint den);
        logic signed [127:0] prod;
        logic signed [127:0] quo;
        prod = 128'(signed'(a)) * 128'(signed'(c));
        quo = prod / 128'(signed'(den));
        return longint'(quo);
    endfunction

    function automatic logic [23:0] clamp_coord(input longint v);
        if (v > 64'sd8388607) v = 8388607;
        if (v < -64'sd8388608) v = -8388608;
        return v[23:0];
    endfunction

    // Work out the result for one accepted item and queue it.
    function void note_item(input logic [23:0] sxr, syr, exr, eyr, cxr, cyr,
                            input logic [22:0] rad, input logic own);
        t_hit_res            res;
        longint              sx, sy, ex, ey, cx, cy, dx, dy, fx, fy, rr;
        longint              dd, fd, cc, s, c;
        logic signed [127:0] disc;
        res = '0;
        sx = longint'(signed'(sxr)); sy = longint'(signed'(syr));
        ex = longint'(signed'(exr)); ey = longint'(signed'(eyr));
        cx = longint'(signed'(cxr)); cy = longint'(signed'(cyr));
        rr = longint'(rad);
        dx = ex - sx; dy = ey - sy;
        fx = sx - cx; fy = sy - cy;
        if (own) begin
            res.skipped = 1'b1;
        end else if (dx != 0) begin
            dd = dx * dx + dy * dy;
            fd = fx * dx + fy * dy;
            cc = fx * fx + fy * fy - rr * rr;
            disc = 128'(signed'(fd)) * 128'(signed'(fd))
                 - 128'(signed'(dd)) * 128'(signed'(cc));
            if (disc > 0) begin
                s = isqrt(disc);
                if (fd > 0) c = s - fd;
                else if (fd < 0) c = -fd - s;
                else c = (dx > 0) ? -s : s;
                if ((c < 0 ? -c : c) < dd) begin
                    res.hit = 1'b1;
                    res.hx = clamp_coord(sx + scaled_offset(dx, c, dd));
                    res.hy = clamp_coord(sy + scaled_offset(dy, c, dd));
                end
            end
        end
        expected_hits.push_back(res);
    endfunction

    function void check_result(input logic hit, input logic [23:0] hx, hy,
                               input logic skipped);
        t_hit_res exp_r;
        if (expected_hits.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result at %0t", $time);
            return;
        end
        exp_r = expected_hits.pop_front();
        if (exp_r.hit !== hit || exp_r.hx !== hx || exp_r.hy !== hy
                || exp_r.skipped !== skipped) begin
            mismatches++;
            if (mismatches <= 10)
                $display({"mismatch at %0t: exp hit=%0b x=%h y=%h skip=%0b,",
                          " got hit=%0b x=%h y=%h skip=%0b"},
                         $time, exp_r.hit, exp_r.hx, exp_r.hy, exp_r.skipped,
                         hit, hx, hy, skipped);
        end
    endfunction
endclass

module testbench;
    localparam int LATENCY     = 85;
    localparam int CYCLE_LIMIT = 400000;

    logic        i_clk;
    logic        i_rst_n;
    logic        push;
    logic        full;
    logic        empty;
    logic        pop;
    logic [23:0] i_start_x, i_start_y, i_end_x, i_end_y, i_circle_x, i_circle_y;
    logic [22:0] i_circle_radius;
    logic        i_own_shot;
    logic        o_hit, o_skipped;
    logic [23:0] o_hit_x, o_hit_y;

    hit_scoreboard board;
    int            cycle_count;
    bit            calm_tail;      // no idling near the end
    bit            hold_results;   // long receiver stall

    segment_circle_hit_test_unit uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .push(push), .full(full),
        .i_start_x(i_start_x), .i_start_y(i_start_y),
        .i_end_x(i_end_x), .i_end_y(i_end_y),
        .i_circle_x(i_circle_x), .i_circle_y(i_circle_y),
        .i_circle_radius(i_circle_radius), .i_own_shot(i_own_shot),
        .empty(empty), .pop(pop), .o_hit(o_hit), .o_hit_x(o_hit_x),
        .o_hit_y(o_hit_y), .o_skipped(o_skipped)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog: ends the run if the block hangs.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("** segment_circle_hit_test_unit: FAILED **");
            $finish;
        end
    end

    // Sample results at the rising edge: a pop with data present moves one item.
    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty)
            board.check_result(o_hit, o_hit_x, o_hit_y, o_skipped);
    end

    // Receiver: random stall bursts, plus one long hold-off when asked.
    initial begin
        int gap;
        pop = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_results) begin
                pop <= 1'b0;
                repeat (300) @(negedge i_clk);
                hold_results = 1'b0;
            end else if (!calm_tail && $urandom_range(0, 9) == 0) begin
                gap = $urandom_range(1, 7);
                pop <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end else begin
                pop <= 1'b1;
            end
        end
    end

    // Offer one item and hold it until the block takes it; caller owns the
    // falling edge, so push stays high across back-to-back items.
    task automatic send_item(input logic [23:0] sx, sy, ex, ey, cx, cy,
                             input logic [22:0] rad, input logic own);
        int gap;
        if (!calm_tail && $urandom_range(0, 9) == 0) begin
            gap = $urandom_range(1, 7);
            push <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        push <= 1'b1;
        i_start_x <= sx; i_start_y <= sy; i_end_x <= ex; i_end_y <= ey;
        i_circle_x <= cx; i_circle_y <= cy;
        i_circle_radius <= rad; i_own_shot <= own;
        do @(posedge i_clk); while (full);
        board.note_item(sx, sy, ex, ey, cx, cy, rad, own);
        @(negedge i_clk);
    endtask

    task automatic stop_push();
        push <= 1'b0;
    endtask

    // Geometry well-suited for hits: nearby circle, segment passing through it.
    task automatic send_shot(input int span);
        logic [23:0] sx, sy, cx, cy;
        sx = 24'($urandom_range(0, 2 * span) - span);
        sy = 24'($urandom_range(0, 2 * span) - span);
        cx = 24'($urandom_range(0, 2 * span) - span);
        cy = 24'($urandom_range(0, 2 * span) - span);
        send_item(sx, sy, 24'(2 * int'(signed'(cx)) - int'(signed'(sx)) + $urandom_range(0, 64) - 32),
                  24'(2 * int'(signed'(cy)) - int'(signed'(sy)) + $urandom_range(0, 64) - 32),
                  cx, cy, 23'($urandom_range(1, span)), $urandom_range(0, 15) == 0);
    endtask

    task automatic drain();
        stop_push();
        while (board.expected_hits.size() != 0) @(negedge i_clk);
    endtask

    initial begin
        logic [23:0] mx, mn;
        board = new();
        cycle_count = 0;
        calm_tail = 1'b0;
        hold_results = 1'b0;
        push = 1'b0;
        i_start_x = '0; i_start_y = '0; i_end_x = '0; i_end_y = '0;
        i_circle_x = '0; i_circle_y = '0; i_circle_radius = '0; i_own_shot = 1'b0;
        i_rst_n = 1'b0;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        mx = 24'h7fffff; mn = 24'h800000;
        // Directed: own shot, vertical, point segment, miss, tangent, clean hit,
        // both directions, equal distances, extremes and saturation.
        send_item(0, 0, 1000, 0, 500, 0, 100, 1'b1);
        send_item(100, 0, 100, 1000, 100, 500, 50, 1'b0);
        send_item(5, 5, 5, 5, 0, 0, 100, 1'b0);
        send_item(0, 0, 1000, 0, 500, 500, 100, 1'b0);
        send_item(0, 0, 1000, 0, 500, 100, 100, 1'b0);
        send_item(0, 0, 1000, 0, 500, 0, 100, 1'b0);
        send_item(1000, 0, 0, 0, 500, 0, 100, 1'b0);
        send_item(0, 0, 1000, 300, 500, 150, 256, 1'b0);
        send_item(0, 0, 100, 0, 0, 0, 50, 1'b0);
        send_item(100, 0, 0, 0, 100, 0, 50, 1'b0);
        send_item(0, 0, 100, 0, 500, 0, 100, 1'b0);
        send_item(mn, mn, mx, mx, 0, 0, 23'h7fffff, 1'b0);
        send_item(mx, mx, mn, mn, 0, 0, 23'h7fffff, 1'b0);
        send_item(mn, mx, mx, mn, mx, mx, 23'h7fffff, 1'b0);
        send_item(mx, 0, mn, 0, mn, mn, 23'h7fffff, 1'b0);
        send_item(mn, 0, mx, 1, mx, mn, 0, 1'b0);
        send_item(mx, mx, mx - 1, mx, mx, mx, 10, 1'b0);
        send_item(mn, mn, mn + 1, mn, mn, mn, 10, 1'b0);
        send_item(0, 0, 3000, 0, 1500, 0, 23'h7fffff, 1'b0);

        // Pause until everything returns.
        drain();

        // Long receiver hold-off while items keep coming, fills the queue.
        hold_results = 1'b1;
        repeat (40) send_shot(2000);

        for (int n = 0; n < 1180; n++) begin
            if (n > 1050) calm_tail = 1'b1;
            case ($urandom_range(0, 9))
                0, 1: send_item(24'($urandom), 24'($urandom), 24'($urandom),
                                24'($urandom), 24'($urandom), 24'($urandom),
                                23'($urandom), 1'($urandom_range(0, 1)));
                2: send_shot(8000000);
                default: send_shot($urandom_range(4, 60000));
            endcase
        end
        drain();
        repeat (LATENCY + 20) @(negedge i_clk);

        if (board.mismatches == 0 && board.expected_hits.size() == 0)
            $display("** segment_circle_hit_test_unit: PASSED **");
        else
            $display("** segment_circle_hit_test_unit: FAILED **");
        $finish;
    end
endmodule
`default_nettype wire
